[sv/nearest_box_along_axis_defines.svh]
// Assertion macros for the checks in the top-level file of this block.
`ifndef NEAREST_BOX_ALONG_AXIS_DEFINES_SVH
`define NEAREST_BOX_ALONG_AXIS_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NBAA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nearest_box_along_axis: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define NBAA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nearest_box_along_axis: assertion failed");

`endif

[sv/nbaa_pkg.sv]
package nbaa_pkg;

  localparam int ID_BITS    = 16;
  localparam int COORD_BITS = 32;
  localparam int SCALE_BITS = 16;
  localparam int PROD_BITS  = 2 * SCALE_BITS;
  localparam int SIZE_BITS  = 24;
  localparam int HALF_BITS  = SIZE_BITS - 1;
  localparam int FRAC_BITS  = 8;
  // Walls are a centre plus or minus a half extent.
  localparam int WALL_BITS  = COORD_BITS + 2;
  localparam int TRUNC_BITS = WALL_BITS - FRAC_BITS;
  localparam int GAP_BITS   = WALL_BITS + 1;
  localparam int ADDR_BITS  = 5;
  localparam int REG_BITS   = 3;
  localparam int DATA_BITS  = 32;

  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = 2;
  localparam int Q_CNT_BITS = 3;

  // 100000.0 in Q24.8.
  localparam logic signed [GAP_BITS-1:0]   START_GAP   = 35'sd25600000;
  localparam logic signed [COORD_BITS-1:0] START_OUT   = 32'sd25600000;
  localparam logic [WALL_BITS-1:0]         ROUND_UNIT  = 34'd255;

  localparam logic [REG_BITS-1:0] REG_SELF_ID     = 3'd0;
  localparam logic [REG_BITS-1:0] REG_SELF_X      = 3'd1;
  localparam logic [REG_BITS-1:0] REG_SELF_Y      = 3'd2;
  localparam logic [REG_BITS-1:0] REG_SELF_WIDTH  = 3'd3;
  localparam logic [REG_BITS-1:0] REG_SELF_HEIGHT = 3'd4;
  localparam logic [REG_BITS-1:0] REG_SWEEP_AXIS  = 3'd5;
  localparam logic [REG_BITS-1:0] REG_SWEEP_SIGN  = 3'd6;

  typedef struct packed {
    logic [ID_BITS-1:0]           box_id;
    logic signed [COORD_BITS-1:0] box_x;
    logic signed [COORD_BITS-1:0] box_y;
    logic [SCALE_BITS-1:0]        body_scale_x;
    logic [SCALE_BITS-1:0]        body_scale_y;
    logic [SCALE_BITS-1:0]        shape_scale_x;
    logic [SCALE_BITS-1:0]        shape_scale_y;
    logic                         last_box;
  } nbaa_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] gap;
    logic [ID_BITS-1:0]           hit_id;
    logic                         hit_found;
  } nbaa_out_t;

  typedef struct packed {
    logic [ID_BITS-1:0]           self_id;
    logic signed [COORD_BITS-1:0] self_x;
    logic signed [COORD_BITS-1:0] self_y;
    logic [SIZE_BITS-1:0]         self_width;
    logic [SIZE_BITS-1:0]         self_height;
    logic                         sweep_axis;
    logic                         sweep_sign;
  } nbaa_cfg_t;

  // Moving-box bounds derived from the registers.
  typedef struct packed {
    logic signed [TRUNC_BITS-1:0] lo_t;
    logic signed [TRUNC_BITS-1:0] hi_t;
    logic signed [WALL_BITS-1:0]  move_wall;
  } nbaa_geo_t;

  // One classified obstacle as it sits in the queue.
  typedef struct packed {
    logic [ID_BITS-1:0]          id;
    logic                        last;
    logic                        skip;
    logic signed [WALL_BITS-1:0] cross_lo;
    logic signed [WALL_BITS-1:0] cross_hi;
    logic signed [WALL_BITS-1:0] move_wall;
  } nbaa_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } nbaa_q_stat_t;

  function automatic logic signed [WALL_BITS-1:0] ext_coord(
      input logic signed [COORD_BITS-1:0] c);
    return {{(WALL_BITS-COORD_BITS){c[COORD_BITS-1]}}, c};
  endfunction

  function automatic logic signed [WALL_BITS-1:0] ext_half(input logic [HALF_BITS-1:0] h);
    return {{(WALL_BITS-HALF_BITS){1'b0}}, h};
  endfunction

  // Truncation toward zero to a whole unit, in whole units.
  function automatic logic signed [TRUNC_BITS-1:0] trunc_unit(
      input logic signed [WALL_BITS-1:0] v);
    logic [WALL_BITS-1:0] adj;
    adj = v[WALL_BITS-1] ? (v + ROUND_UNIT) : v;
    return adj[WALL_BITS-1:FRAC_BITS];
  endfunction

endpackage

[sv/nbaa_front.sv]
module nbaa_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  nbaa_pkg::nbaa_in_t  in_data,
  input  nbaa_pkg::nbaa_cfg_t cfg,
  input  nbaa_pkg::nbaa_q_stat_t q_stat,
  output logic                push,
  output nbaa_pkg::nbaa_item_t push_item,
  output nbaa_pkg::nbaa_geo_t geo
);

  logic                                  f1_valid_r, f1_valid_nxt;
  logic [nbaa_pkg::ID_BITS-1:0]          f1_id_r;
  logic signed [nbaa_pkg::COORD_BITS-1:0] f1_x_r, f1_y_r;
  logic [nbaa_pkg::PROD_BITS-1:0]        f1_prod_x_r, f1_prod_y_r;
  logic                                  f1_last_r;

  logic                 f2_valid_r, f2_valid_nxt;
  nbaa_pkg::nbaa_item_t f2_item_r, f2_item_nxt;
  nbaa_pkg::nbaa_geo_t  geo_r, geo_nxt;

  logic f1_adv, f2_adv;

  logic signed [nbaa_pkg::WALL_BITS-1:0] bx, by, bhx, bhy, b_c, b_h, b_m, b_mh;
  logic signed [nbaa_pkg::WALL_BITS-1:0] sx, sy, shw, shh, s_c, s_h, s_m, s_mh;

  assign f2_adv   = !f2_valid_r || !q_stat.full;
  assign f1_adv   = !f1_valid_r || f2_adv;
  assign in_stall = f1_valid_r && !f1_adv;
  assign push     = f2_valid_r && !q_stat.full;
  assign push_item = f2_item_r;
  assign geo      = geo_r;

  assign f1_valid_nxt = f1_adv ? in_valid : f1_valid_r;
  assign f2_valid_nxt = f2_adv ? f1_valid_r : f2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= f1_valid_nxt;
      f2_valid_r <= f2_valid_nxt;
    end
  end

  // Extent products are registered before any wall is formed.
  always_ff @(posedge clk) begin
    if (f1_adv) begin
      f1_id_r     <= in_data.box_id;
      f1_x_r      <= in_data.box_x;
      f1_y_r      <= in_data.box_y;
      f1_last_r   <= in_data.last_box;
      f1_prod_x_r <= nbaa_pkg::PROD_BITS'(in_data.body_scale_x)
                     * nbaa_pkg::PROD_BITS'(in_data.shape_scale_x);
      f1_prod_y_r <= nbaa_pkg::PROD_BITS'(in_data.body_scale_y)
                     * nbaa_pkg::PROD_BITS'(in_data.shape_scale_y);
    end
    if (f2_adv) begin
      f2_item_r <= f2_item_nxt;
    end
    geo_r <= geo_nxt;
  end

  always_comb begin
    bx  = nbaa_pkg::ext_coord(f1_x_r);
    by  = nbaa_pkg::ext_coord(f1_y_r);
    // Half extent is the Q16.8 product shifted by one more place.
    bhx = nbaa_pkg::ext_half(f1_prod_x_r[nbaa_pkg::PROD_BITS-1:nbaa_pkg::FRAC_BITS+1]);
    bhy = nbaa_pkg::ext_half(f1_prod_y_r[nbaa_pkg::PROD_BITS-1:nbaa_pkg::FRAC_BITS+1]);
    if (cfg.sweep_axis) begin
      b_c = bx; b_h = bhx; b_m = by; b_mh = bhy;
    end else begin
      b_c = by; b_h = bhy; b_m = bx; b_mh = bhx;
    end
    f2_item_nxt.id        = f1_id_r;
    f2_item_nxt.last      = f1_last_r;
    f2_item_nxt.skip      = (f1_id_r == cfg.self_id);
    f2_item_nxt.cross_lo  = b_c - b_h;
    f2_item_nxt.cross_hi  = b_c + b_h;
    f2_item_nxt.move_wall = cfg.sweep_sign ? (b_m - b_mh) : (b_m + b_mh);
  end

  always_comb begin
    sx  = nbaa_pkg::ext_coord(cfg.self_x);
    sy  = nbaa_pkg::ext_coord(cfg.self_y);
    shw = nbaa_pkg::ext_half(cfg.self_width[nbaa_pkg::SIZE_BITS-1:1]);
    shh = nbaa_pkg::ext_half(cfg.self_height[nbaa_pkg::SIZE_BITS-1:1]);
    if (cfg.sweep_axis) begin
      s_c = sx; s_h = shw; s_m = sy; s_mh = shh;
    end else begin
      s_c = sy; s_h = shh; s_m = sx; s_mh = shw;
    end
    geo_nxt.lo_t      = nbaa_pkg::trunc_unit(s_c - s_h);
    geo_nxt.hi_t      = nbaa_pkg::trunc_unit(s_c + s_h);
    geo_nxt.move_wall = cfg.sweep_sign ? (s_m + s_mh) : (s_m - s_mh);
  end

endmodule

[sv/nbaa_fifo.sv]
module nbaa_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  nbaa_pkg::nbaa_item_t   push_item,
  input  logic                   pop,
  output nbaa_pkg::nbaa_item_t   head_item,
  output nbaa_pkg::nbaa_q_stat_t q_stat
);

  nbaa_pkg::nbaa_item_t mem [nbaa_pkg::Q_DEPTH];

  logic [nbaa_pkg::Q_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [nbaa_pkg::Q_CNT_BITS-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == nbaa_pkg::Q_CNT_BITS'(nbaa_pkg::Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_item    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

[sv/nbaa_back.sv]
module nbaa_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  nbaa_pkg::nbaa_cfg_t    cfg,
  input  nbaa_pkg::nbaa_geo_t    geo,
  input  nbaa_pkg::nbaa_q_stat_t q_stat,
  input  nbaa_pkg::nbaa_item_t   head_item,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output nbaa_pkg::nbaa_out_t    out_data
);

  logic                                  s1_valid_r, s1_valid_nxt;
  logic                                  s1_cand_r, s1_last_r;
  logic signed [nbaa_pkg::GAP_BITS-1:0]  s1_diff_r;
  logic [nbaa_pkg::ID_BITS-1:0]          s1_id_r;

  logic signed [nbaa_pkg::GAP_BITS-1:0]  best_r, best_nxt;
  logic [nbaa_pkg::ID_BITS-1:0]          best_id_r, best_id_nxt;
  logic                                  any_r, any_nxt;

  logic                out_valid_r, out_valid_nxt;
  nbaa_pkg::nbaa_out_t out_data_r, out_data_nxt;

  logic signed [nbaa_pkg::TRUNC_BITS-1:0] b_lo_t, b_hi_t;
  logic signed [nbaa_pkg::GAP_BITS-1:0]   diff, start, best, win_gap;
  logic                                   overlap, sign_ok, cand;
  logic                                   blocked, consume, better, take, win_any;
  logic [nbaa_pkg::ID_BITS-1:0]           win_id;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A finished query can only leave stage one when the output register frees.
  assign blocked = s1_valid_r && s1_last_r && out_valid_r && out_stall;
  assign consume = s1_valid_r && !blocked;
  assign pop     = !q_stat.empty && (!s1_valid_r || !blocked);
  assign s1_valid_nxt = (!s1_valid_r || !blocked) ? pop : s1_valid_r;

  always_comb begin
    b_lo_t  = nbaa_pkg::trunc_unit(head_item.cross_lo);
    b_hi_t  = nbaa_pkg::trunc_unit(head_item.cross_hi);
    overlap = (geo.lo_t < b_hi_t) && (b_lo_t < geo.hi_t);
    diff    = {head_item.move_wall[nbaa_pkg::WALL_BITS-1], head_item.move_wall}
              - {geo.move_wall[nbaa_pkg::WALL_BITS-1], geo.move_wall};
    sign_ok = cfg.sweep_sign ? !diff[nbaa_pkg::GAP_BITS-1]
                             : (diff[nbaa_pkg::GAP_BITS-1] || (diff == '0));
    cand    = !head_item.skip && overlap && sign_ok;
  end

  always_comb begin
    start   = cfg.sweep_sign ? nbaa_pkg::START_GAP : -nbaa_pkg::START_GAP;
    best    = any_r ? best_r : start;
    better  = cfg.sweep_sign ? (best > s1_diff_r) : (best < s1_diff_r);
    take    = consume && s1_cand_r && better;
    win_gap = take ? s1_diff_r : best;
    win_id  = take ? s1_id_r : best_id_r;
    win_any = any_r || take;

    best_nxt      = take ? s1_diff_r : best_r;
    best_id_nxt   = win_id;
    any_nxt       = win_any;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (consume && s1_last_r) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.gap       = win_gap[nbaa_pkg::COORD_BITS-1:0];
      out_data_nxt.hit_id    = win_any ? win_id : '0;
      out_data_nxt.hit_found = win_any;
      best_nxt               = nbaa_pkg::START_GAP;
      best_id_nxt            = '0;
      any_nxt                = 1'b0;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      best_r      <= nbaa_pkg::START_GAP;
      best_id_r   <= '0;
      any_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      best_r      <= best_nxt;
      best_id_r   <= best_id_nxt;
      any_r       <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_cand_r <= cand;
      s1_diff_r <= diff;
      s1_id_r   <= head_item.id;
      s1_last_r <= head_item.last;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

[sv/nearest_box_along_axis.sv]
// Nearest obstacle ahead of a moving box along one axis.
// The APB-style port holds the moving box: id, centre, full size, axis and
// direction. Writes complete in the access cycle; pready is tied high.
// Obstacle words arrive on the in_ channel (valid/stall) and the block
// accepts one word per cycle while in_stall is low. The word flagged
// last_box closes the query and causes one result word on the out_
// channel: gap, hit_id and hit_found. Words that are not last cause no
// result. The result of a query passes through two front stages (extent
// multiply, wall forming), the queue, then one back stage before the
// output register. Sustained rate is one word per cycle without stalls.
// When the receiver stalls, the result holds in the output register, the back
// end stops only once a further result is due, the four-entry queue fills,
// and then in_stall rises.
// Reset is synchronous and active low: it empties the pipeline and queue,
// clears the running best and restores the registers (sweep_sign to 1).
// The user must write the registers only while no query is in flight; the block does not enforce it.
`include "nearest_box_along_axis_defines.svh"

module nearest_box_along_axis (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  nbaa_pkg::nbaa_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output nbaa_pkg::nbaa_out_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nbaa_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [nbaa_pkg::DATA_BITS-1:0]      pwdata,
  output logic [nbaa_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready
);

  // Configuration registers, one word per register at byte address 4*i.
  nbaa_pkg::nbaa_cfg_t cfg_r, cfg_nxt;

  logic                            wr_en;
  logic [nbaa_pkg::REG_BITS-1:0]   reg_idx;

  nbaa_pkg::nbaa_q_stat_t q_stat;
  nbaa_pkg::nbaa_item_t   push_item, head_item;
  nbaa_pkg::nbaa_geo_t    geo;
  logic                   push, pop;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[nbaa_pkg::ADDR_BITS-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        nbaa_pkg::REG_SELF_ID:     cfg_nxt.self_id     = pwdata[nbaa_pkg::ID_BITS-1:0];
        nbaa_pkg::REG_SELF_X:      cfg_nxt.self_x      = pwdata[nbaa_pkg::COORD_BITS-1:0];
        nbaa_pkg::REG_SELF_Y:      cfg_nxt.self_y      = pwdata[nbaa_pkg::COORD_BITS-1:0];
        nbaa_pkg::REG_SELF_WIDTH:  cfg_nxt.self_width  = pwdata[nbaa_pkg::SIZE_BITS-1:0];
        nbaa_pkg::REG_SELF_HEIGHT: cfg_nxt.self_height = pwdata[nbaa_pkg::SIZE_BITS-1:0];
        nbaa_pkg::REG_SWEEP_AXIS:  cfg_nxt.sweep_axis  = pwdata[0];
        nbaa_pkg::REG_SWEEP_SIGN:  cfg_nxt.sweep_sign  = pwdata[0];
        default: begin
          // Addresses beyond the register list are ignored.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.self_id     <= '0;
      cfg_r.self_x      <= '0;
      cfg_r.self_y      <= '0;
      cfg_r.self_width  <= '0;
      cfg_r.self_height <= '0;
      cfg_r.sweep_axis  <= 1'b0;
      cfg_r.sweep_sign  <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read-back is zero-extended to the data width.
  always_comb begin
    unique case (reg_idx)
      nbaa_pkg::REG_SELF_ID:     prdata = nbaa_pkg::DATA_BITS'(cfg_r.self_id);
      nbaa_pkg::REG_SELF_X:      prdata = cfg_r.self_x;
      nbaa_pkg::REG_SELF_Y:      prdata = cfg_r.self_y;
      nbaa_pkg::REG_SELF_WIDTH:  prdata = nbaa_pkg::DATA_BITS'(cfg_r.self_width);
      nbaa_pkg::REG_SELF_HEIGHT: prdata = nbaa_pkg::DATA_BITS'(cfg_r.self_height);
      nbaa_pkg::REG_SWEEP_AXIS:  prdata = nbaa_pkg::DATA_BITS'(cfg_r.sweep_axis);
      nbaa_pkg::REG_SWEEP_SIGN:  prdata = nbaa_pkg::DATA_BITS'(cfg_r.sweep_sign);
      default:                   prdata = '0;
    endcase
  end

  // The front end forms extents and walls and decides whether the box is
  // the moving box itself; it also keeps the moving box's own bounds.
  nbaa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item),
    .geo       (geo)
  );

  // The queue lets the front keep taking words while the back waits.
  nbaa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  // The back end runs the overlap test, the gap and the running best, and
  // holds the result word until the receiver takes it.
  nbaa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .geo       (geo),
    .q_stat    (q_stat),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The front never writes into a full queue, and the back never reads an
  // empty one.
  `NBAA_ASSERT_NOW(a_no_overflow, q_stat.full, !push)
  `NBAA_ASSERT_NOW(a_no_underflow, q_stat.empty, !pop)
  `NBAA_ASSERT_NOW(a_q_flags, q_stat.full, !q_stat.empty)
  // A query with no hit reports id zero and the start value for its direction.
  `NBAA_ASSERT_NOW(a_empty_query, out_valid && !out_data.hit_found, (out_data.hit_id == '0) && ((out_data.gap == nbaa_pkg::START_OUT) || (out_data.gap == -nbaa_pkg::START_OUT)))

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

  // Scoreboard: keeps its own copy of the moving box registers and of the
  // running nearest hit, predicts one result word per closed query and checks
  // result words in order against those predictions.
  class nearest_hit_board;
    nbaa_pkg::nbaa_cfg_t          regs;
    longint                       best_gap;
    logic [nbaa_pkg::ID_BITS-1:0] best_id;
    bit                           any_found;
    nbaa_pkg::nbaa_out_t          hits_due[$];
    int                           errors;

    function new();
      regs = '0;
      regs.sweep_sign = 1'b1;
      best_gap = longint'(nbaa_pkg::START_GAP);
      best_id = '0;
      any_found = 1'b0;
      errors = 0;
    endfunction

    function void write_field(logic [nbaa_pkg::REG_BITS-1:0] idx,
                              logic [nbaa_pkg::DATA_BITS-1:0] value);
      case (idx)
        nbaa_pkg::REG_SELF_ID:     regs.self_id = value[nbaa_pkg::ID_BITS-1:0];
        nbaa_pkg::REG_SELF_X:      regs.self_x = value[nbaa_pkg::COORD_BITS-1:0];
        nbaa_pkg::REG_SELF_Y:      regs.self_y = value[nbaa_pkg::COORD_BITS-1:0];
        nbaa_pkg::REG_SELF_WIDTH:  regs.self_width = value[nbaa_pkg::SIZE_BITS-1:0];
        nbaa_pkg::REG_SELF_HEIGHT: regs.self_height = value[nbaa_pkg::SIZE_BITS-1:0];
        nbaa_pkg::REG_SWEEP_AXIS:  regs.sweep_axis = value[0];
        nbaa_pkg::REG_SWEEP_SIGN:  regs.sweep_sign = value[0];
        default: ;
      endcase
    endfunction

    function longint start_gap();
      return regs.sweep_sign ? longint'(nbaa_pkg::START_GAP)
                             : -longint'(nbaa_pkg::START_GAP);
    endfunction

    function void note_word(nbaa_pkg::nbaa_in_t w);
      longint bx, by, ex, ey, sx, sy;
      longint c_s, h_s, c_b, h_b, m_s, mh_s, m_b, mh_b, kept, diff, fin;
      bit take;
      nbaa_pkg::nbaa_out_t hit;
      bx = longint'($signed(w.box_x));
      by = longint'($signed(w.box_y));
      // Full extents: Q8.8 times Q8.8 gives Q16.16, truncated to Q16.8.
      ex = (longint'(w.body_scale_x) * longint'(w.shape_scale_x)) >>> 8;
      ey = (longint'(w.body_scale_y) * longint'(w.shape_scale_y)) >>> 8;
      sx = longint'($signed(regs.self_x));
      sy = longint'($signed(regs.self_y));
      if (w.box_id != regs.self_id) begin
        if (!regs.sweep_axis) begin
          c_s = sy; h_s = longint'(regs.self_height) >>> 1; c_b = by; h_b = ey >>> 1;
          m_s = sx; mh_s = longint'(regs.self_width) >>> 1; m_b = bx; mh_b = ex >>> 1;
        end else begin
          c_s = sx; h_s = longint'(regs.self_width) >>> 1; c_b = bx; h_b = ex >>> 1;
          m_s = sy; mh_s = longint'(regs.self_height) >>> 1; m_b = by; mh_b = ey >>> 1;
        end
        // Integer division truncates toward zero, which is the whole-unit
        // truncation applied to the cross-axis bounds.
        if ((c_s - h_s) / 256 < (c_b + h_b) / 256 &&
            (c_b - h_b) / 256 < (c_s + h_s) / 256) begin
          kept = any_found ? best_gap : start_gap();
          if (regs.sweep_sign) begin
            diff = (m_b - mh_b) - (m_s + mh_s);
            take = diff >= 0 && diff < kept;
          end else begin
            diff = (m_b + mh_b) - (m_s - mh_s);
            take = diff <= 0 && diff > kept;
          end
          if (take) begin
            best_gap = diff;
            best_id = w.box_id;
            any_found = 1'b1;
          end
        end
      end
      if (w.last_box) begin
        fin = any_found ? best_gap : start_gap();
        hit.gap = fin[nbaa_pkg::COORD_BITS-1:0];
        hit.hit_id = any_found ? best_id : '0;
        hit.hit_found = any_found;
        hits_due.push_back(hit);
        best_gap = longint'(nbaa_pkg::START_GAP);
        best_id = '0;
        any_found = 1'b0;
      end
    endfunction

    function void check_hit(nbaa_pkg::nbaa_out_t got);
      nbaa_pkg::nbaa_out_t due;
      if (hits_due.size() == 0) begin
        $error("result word with no query closed: gap %0d hit_id %0d hit_found %0d",
               $signed(got.gap), got.hit_id, got.hit_found);
        errors++;
        return;
      end
      due = hits_due.pop_front();
      if (got.gap !== due.gap) begin
        $error("gap: expected %0d, got %0d", $signed(due.gap), $signed(got.gap));
        errors++;
      end
      if (got.hit_id !== due.hit_id) begin
        $error("hit_id: expected %0d, got %0d", due.hit_id, got.hit_id);
        errors++;
      end
      if (got.hit_found !== due.hit_found) begin
        $error("hit_found: expected %0d, got %0d", due.hit_found, got.hit_found);
        errors++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  nbaa_pkg::nbaa_in_t             in_data;
  logic                           out_valid;
  logic                           out_stall;
  nbaa_pkg::nbaa_out_t            out_data;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [nbaa_pkg::ADDR_BITS-1:0] paddr;
  logic [nbaa_pkg::DATA_BITS-1:0] pwdata;
  logic [nbaa_pkg::DATA_BITS-1:0] prdata;
  logic                           pready;

  nearest_hit_board board;

  // Idling controls, in percent of cycles, changed from phase to phase.
  int idle_pct;
  int stall_pct;
  // Cycles for which the receiver still holds off unconditionally.
  int hold_left;

  nearest_box_along_axis u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A hard ceiling on the run, set well beyond the length of the slowest legal run.
  initial begin
    #2_000_000;
    $display("** nearest_box_along_axis: FAILED **");
    $finish;
  end

  // Receiver: a long hold-off when one is requested, random stalls otherwise.
  // The stall changes only at the falling edge, one assignment per edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Every result word taken at a rising edge is checked against the oldest
  // prediction. Values read here are those from just before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_hit(out_data);
    end
  end

  function automatic nbaa_pkg::nbaa_in_t box(logic [nbaa_pkg::ID_BITS-1:0] id,
                                             logic [nbaa_pkg::COORD_BITS-1:0] x,
                                             logic [nbaa_pkg::COORD_BITS-1:0] y,
                                             logic [15:0] bsx, logic [15:0] bsy,
                                             logic [15:0] ssx, logic [15:0] ssy,
                                             logic last);
    nbaa_pkg::nbaa_in_t w;
    w.box_id = id;
    w.box_x = x;
    w.box_y = y;
    w.body_scale_x = bsx;
    w.body_scale_y = bsy;
    w.shape_scale_x = ssx;
    w.shape_scale_y = ssy;
    w.last_box = last;
    return w;
  endfunction

  // Random obstacle. Most are placed within a few dozen units of the moving
  // box on a coarse grid, so that overlaps, hits and ties are common; some
  // reuse the moving box's own id; the rest are raw noise over every bit.
  function automatic nbaa_pkg::nbaa_in_t make_box(logic last);
    nbaa_pkg::nbaa_in_t w;
    logic [159:0] noise;
    int unsigned pick;
    int off_x;
    int off_y;
    pick = $urandom_range(99);
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w = noise[$bits(nbaa_pkg::nbaa_in_t)-1:0];
    if (pick >= 15) begin
      off_x = int'($urandom_range(0, 511)) * 32 - 8192;
      off_y = int'($urandom_range(0, 511)) * 32 - 8192;
      w.box_x = board.regs.self_x + off_x;
      w.box_y = board.regs.self_y + off_y;
      w.body_scale_x = 16'($urandom_range(0, 4) * 128);
      w.body_scale_y = 16'($urandom_range(0, 4) * 128);
      w.shape_scale_x = 16'($urandom_range(0, 1024));
      w.shape_scale_y = 16'($urandom_range(0, 1024));
      if (pick < 25) begin
        w.box_id = board.regs.self_id;
      end
    end
    w.last_box = last;
    return w;
  endfunction

  function automatic nbaa_pkg::nbaa_cfg_t random_regs();
    nbaa_pkg::nbaa_cfg_t c;
    c.self_id = nbaa_pkg::ID_BITS'($urandom);
    c.self_x = $urandom;
    c.self_y = $urandom;
    c.self_width = nbaa_pkg::SIZE_BITS'($urandom_range(0, 8192));
    c.self_height = nbaa_pkg::SIZE_BITS'($urandom_range(0, 8192));
    c.sweep_axis = 1'($urandom);
    c.sweep_sign = 1'($urandom);
    return c;
  endfunction

  // Offers one word and waits until it is taken. Valid is only lowered for
  // an idle cycle, and is otherwise left high from the previous word.
  task automatic send_word(input nbaa_pkg::nbaa_in_t w);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    board.note_word(w);
  endtask

  // Stops offering words and waits until every predicted result has come,
  // then lets the pipeline run empty before anything else happens.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.hits_due.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  // One register write: setup cycle, then access cycle.
  task automatic write_reg(input logic [nbaa_pkg::REG_BITS-1:0] idx,
                           input logic [nbaa_pkg::DATA_BITS-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_field(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(input nbaa_pkg::nbaa_cfg_t c);
    settle();
    write_reg(nbaa_pkg::REG_SELF_ID, 32'(c.self_id));
    write_reg(nbaa_pkg::REG_SELF_X, 32'(c.self_x));
    write_reg(nbaa_pkg::REG_SELF_Y, 32'(c.self_y));
    write_reg(nbaa_pkg::REG_SELF_WIDTH, 32'(c.self_width));
    write_reg(nbaa_pkg::REG_SELF_HEIGHT, 32'(c.self_height));
    write_reg(nbaa_pkg::REG_SWEEP_AXIS, 32'(c.sweep_axis));
    write_reg(nbaa_pkg::REG_SWEEP_SIGN, 32'(c.sweep_sign));
  endtask

  // Whole queries of random length until about n words have gone in, so
  // that every phase ends on a closed query.
  task automatic run_queries(input int n, input int max_len);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) begin
        send_word(make_box(i == len - 1));
        sent++;
      end
    end
  endtask

  initial begin
    nbaa_pkg::nbaa_cfg_t c;
    board = new();
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, horizontal sweep to the right: a 4x4 moving box at the
    // origin with id 5.
    c = '0;
    c.self_id = 16'd5;
    c.self_width = 24'd1024;
    c.self_height = 24'd1024;
    c.sweep_sign = 1'b1;
    apply_setting(c);
    // A query holding only the moving box itself reports the start value.
    send_word(box(16'd5, 32'd2560, 32'd0, 16'd256, 16'd256, 16'd256, 16'd256, 1'b1));
    // Ahead, behind, off to the side, then a box touching the leading wall
    // and a second one at the same gap: the earlier of the tie must win.
    send_word(box(16'd7, 32'd2560, 32'd0, 16'd256, 16'd256, 16'd512, 16'd512, 1'b0));
    send_word(box(16'd8, -32'sd2560, 32'd0, 16'd256, 16'd256, 16'd512, 16'd512, 1'b0));
    send_word(box(16'd9, 32'd2000, 32'd25600, 16'd256, 16'd256, 16'd512, 16'd512, 1'b0));
    send_word(box(16'd10, 32'd768, 32'd0, 16'd256, 16'd256, 16'd512, 16'd512, 1'b0));
    send_word(box(16'd11, 32'd768, 32'd0, 16'd256, 16'd256, 16'd512, 16'd512, 1'b0));
    // Zero-sized boxes just past each cross-axis edge, where the whole-unit
    // truncation decides, and one just inside.
    send_word(box(16'd12, 32'd1000, 32'd640, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_word(box(16'd13, 32'd900, -32'sd640, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_word(box(16'd14, 32'd900, 32'd511, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
    // Field extremes, then a nearer hit whose id is zero.
    send_word(box(16'd15, 32'h7fff_ffff, 32'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                  1'b0));
    send_word(box(16'hffff, 32'h8000_0000, 32'h8000_0000, 16'hffff, 16'hffff, 16'hffff,
                  16'hffff, 1'b0));
    send_word(box(16'd0, 32'd1536, -32'sd256, 16'd256, 16'd256, 16'd256, 16'd256, 1'b1));

    // Directed, vertical sweep upwards with self id zero.
    c = '0;
    c.self_x = 32'd2560;
    c.self_y = 32'd2560;
    c.self_width = 24'd512;
    c.self_height = 24'd2048;
    c.sweep_axis = 1'b1;
    c.sweep_sign = 1'b0;
    apply_setting(c);
    send_word(box(16'd0, 32'd2560, 32'd0, 16'd256, 16'd256, 16'd256, 16'd512, 1'b1));
    send_word(box(16'd3, 32'd2560, 32'd0, 16'd256, 16'd256, 16'd256, 16'd512, 1'b0));
    send_word(box(16'd4, 32'd2560, 32'd5000, 16'd256, 16'd256, 16'd256, 16'd512, 1'b0));
    send_word(box(16'd6, 32'd2560, -32'sd3000, 16'd256, 16'd256, 16'd256, 16'd512, 1'b0));
    send_word(box(16'd7, 32'd2560, 32'd1280, 16'd256, 16'd256, 16'd256, 16'd512, 1'b1));

    // Random phases. First with no idling on either side.
    apply_setting(random_regs());
    run_queries(100, 8);

    // Registers at one set of extremes, sender mostly idle.
    c.self_id = 16'hffff;
    c.self_x = 32'h7fff_ffff;
    c.self_y = 32'h8000_0000;
    c.self_width = 24'hff_ffff;
    c.self_height = 24'd0;
    c.sweep_axis = 1'b1;
    c.sweep_sign = 1'b0;
    apply_setting(c);
    idle_pct = 81;
    run_queries(80, 8);

    // Receiver mostly stalling.
    apply_setting(random_regs());
    idle_pct = 0;
    stall_pct = 81;
    run_queries(100, 8);

    // The opposite extremes, both sides idling now and then.
    c.self_id = 16'd0;
    c.self_x = 32'h8000_0000;
    c.self_y = 32'h7fff_ffff;
    c.self_width = 24'd0;
    c.self_height = 24'hff_ffff;
    c.sweep_axis = 1'b0;
    c.sweep_sign = 1'b1;
    apply_setting(c);
    idle_pct = 30;
    stall_pct = 30;
    run_queries(100, 8);

    // Back-pressure: the receiver holds off for a long stretch while every
    // word closes a query, so the obstacle queue fills and the input stalls.
    apply_setting(random_regs());
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 300;
    run_queries(40, 1);
    // The sender then pauses until every outstanding result has arrived.
    settle();
    idle_pct = 30;
    stall_pct = 30;
    run_queries(80, 8);

    settle();
    if (board.errors == 0 && board.hits_due.size() == 0) begin
      $display("** nearest_box_along_axis: PASSED **");
    end else begin
      $display("** nearest_box_along_axis: FAILED **");
    end
    $finish;
  end

endmodule
